>>> design/rdc_pkg.sv
// ---------------------------------------------------------------------------
// rdc_pkg: shared definitions for the range distinct-count window block
// Sizes, the command word that travels from the front end to the back end,
// opcodes and the back-end sequencer states.
// ---------------------------------------------------------------------------
package rdc_pkg;

    // Array and value-space sizes.
    localparam int ARRAY_DEPTH = 1024;
    localparam int VALUE_RANGE = 1024;

    // Fixed widths of the channel fields.
    localparam int FIELD_W = 10;
    localparam int DIST_W  = 11;

    // Derived internal widths.
    localparam int AIDX_W = $clog2(ARRAY_DEPTH);
    localparam int VAL_W  = $clog2(VALUE_RANGE);
    localparam int WIN_W  = $clog2(ARRAY_DEPTH + 1);
    localparam int CNT_W  = WIN_W;
    localparam int CMP_W  = (FIELD_W > WIN_W) ? FIELD_W : WIN_W;
    localparam int VCMP_W = (FIELD_W > VAL_W + 1) ? FIELD_W : VAL_W + 1;

    // Command queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Classified command as held in the queue.
    typedef struct packed
    {
        logic              is_query;
        logic              empty;
        logic [AIDX_W-1:0] pos;
        logic [VAL_W-1:0]  val;
        logic [WIN_W-1:0]  t_low;
        logic [WIN_W-1:0]  t_high;
    } cmd_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_PICK,
        S_ELEM,
        S_OCCWR,
        S_LUPRD
    } back_state_t;

endpackage

>>> design/rdc_item_if.sv
// ---------------------------------------------------------------------------
// rdc_item_if: input item channel
// Valid/ready channel carrying one load or query item per transfer.
// ---------------------------------------------------------------------------
interface rdc_item_if;

    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [rdc_pkg::FIELD_W-1:0] position;
    logic [rdc_pkg::FIELD_W-1:0] element_value;
    logic [rdc_pkg::FIELD_W-1:0] range_left;
    logic [rdc_pkg::FIELD_W-1:0] range_right;

    modport source
    (
        output valid, op, position, element_value, range_left, range_right,
        input  ready
    );

    modport sink
    (
        input  valid, op, position, element_value, range_left, range_right,
        output ready
    );

endinterface

>>> design/rdc_result_if.sv
// ---------------------------------------------------------------------------
// rdc_result_if: result channel
// Valid/ready channel carrying one distinct count per transfer.
// ---------------------------------------------------------------------------
interface rdc_result_if;

    logic                       valid;
    logic                       ready;
    logic [rdc_pkg::DIST_W-1:0] distinct;

    modport source
    (
        output valid, distinct,
        input  ready
    );

    modport sink
    (
        input  valid, distinct,
        output ready
    );

endinterface

>>> design/rdc_front.sv
// ---------------------------------------------------------------------------
// rdc_front: item intake and classification
// Accepts input items, saturates values and the right range end, marks empty ranges,
// drops loads beyond the array and pushes the resulting command.
// ---------------------------------------------------------------------------
module rdc_front
(
    input  logic          clearing,
    rdc_item_if.sink      item,
    output logic          push_valid,
    input  logic          push_ready,
    output rdc_pkg::cmd_t push_data
);

    logic [rdc_pkg::CMP_W-1:0]  hi_sat;
    logic [rdc_pkg::CMP_W-1:0]  lo_ext;
    logic [rdc_pkg::VCMP_W-1:0] val_ext;
    logic                       drop;

    // Intake is held off while the count table is being cleared.
    assign item.ready = !clearing && push_ready;

    // A load beyond the array is taken but produces no command.
    assign drop = (item.op == rdc_pkg::OP_LOAD) &&
                  (rdc_pkg::CMP_W'(item.position) >= rdc_pkg::CMP_W'(rdc_pkg::ARRAY_DEPTH));

    assign push_valid = item.valid && !clearing && !drop;

    // Saturate the range end and the loaded value.
    always_comb
    begin
        lo_ext  = rdc_pkg::CMP_W'(item.range_left);
        val_ext = rdc_pkg::VCMP_W'(item.element_value);
        if (rdc_pkg::CMP_W'(item.range_right) >= rdc_pkg::CMP_W'(rdc_pkg::ARRAY_DEPTH))
        begin
            hi_sat = rdc_pkg::CMP_W'(rdc_pkg::ARRAY_DEPTH - 1);
        end
        else
        begin
            hi_sat = rdc_pkg::CMP_W'(item.range_right);
        end
        if (val_ext >= rdc_pkg::VCMP_W'(rdc_pkg::VALUE_RANGE))
        begin
            val_ext = rdc_pkg::VCMP_W'(rdc_pkg::VALUE_RANGE - 1);
        end
    end

    // Build the command word.
    always_comb
    begin
        push_data.is_query = (item.op == rdc_pkg::OP_QUERY);
        push_data.empty    = lo_ext > hi_sat;
        push_data.pos      = rdc_pkg::AIDX_W'(item.position);
        push_data.val      = rdc_pkg::VAL_W'(val_ext);
        push_data.t_low    = rdc_pkg::WIN_W'(lo_ext);
        push_data.t_high   = rdc_pkg::WIN_W'(hi_sat) + rdc_pkg::WIN_W'(1);
    end

endmodule

>>> design/rdc_queue.sv
// ---------------------------------------------------------------------------
// rdc_queue: command queue
// Small register FIFO that lets the front end run ahead of the back end.
// ---------------------------------------------------------------------------
module rdc_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  rdc_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rdc_pkg::cmd_t pop_data
);

    rdc_pkg::cmd_t               mem_reg [rdc_pkg::QUEUE_DEPTH];
    logic [rdc_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [rdc_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [rdc_pkg::QPTR_W:0]    count_reg;
    logic [rdc_pkg::QPTR_W:0]    count_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != (rdc_pkg::QPTR_W + 1)'(rdc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/rdc_back.sv
// ---------------------------------------------------------------------------
// rdc_back: window engine
// Holds the element array and the occurrence table, walks the window one
// position per step with a read-modify-write of the count, applies loads
// (updating counts for those inside the window) and registers the distinct count for output.
// ---------------------------------------------------------------------------
module rdc_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  rdc_pkg::cmd_t cmd,
    output logic          clearing,
    rdc_result_if.source  result
);

    localparam int AIDX_W = rdc_pkg::AIDX_W;
    localparam int VAL_W  = rdc_pkg::VAL_W;
    localparam int WIN_W  = rdc_pkg::WIN_W;
    localparam int CNT_W  = rdc_pkg::CNT_W;

    // Memories and their registered read data.
    logic [VAL_W-1:0] elem_mem [rdc_pkg::ARRAY_DEPTH];
    logic [CNT_W-1:0] occ_mem  [rdc_pkg::VALUE_RANGE];
    logic [VAL_W-1:0] elem_rdata_reg;
    logic [CNT_W-1:0] occ_rdata_reg;

    // Memory port controls.
    logic              elem_re;
    logic [AIDX_W-1:0] elem_raddr;
    logic              elem_we;
    logic [AIDX_W-1:0] elem_waddr;
    logic [VAL_W-1:0]  elem_wdata;
    logic              occ_re;
    logic [VAL_W-1:0]  occ_raddr;
    logic              occ_we;
    logic [VAL_W-1:0]  occ_waddr;
    logic [CNT_W-1:0]  occ_wdata;

    // Control state.
    rdc_pkg::back_state_t state_reg, state_next;
    logic [VAL_W-1:0] clr_idx_reg, clr_idx_next;
    logic [WIN_W-1:0] wl_reg, wl_next;
    logic [WIN_W-1:0] wh_reg, wh_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state.
    logic [WIN_W-1:0]          tl_reg, tl_next;
    logic [WIN_W-1:0]          th_reg, th_next;
    logic [AIDX_W-1:0]         pos_reg, pos_next;
    logic [VAL_W-1:0]          newval_reg, newval_next;
    logic [VAL_W-1:0]          val_reg, val_next;
    logic                      dir_up_reg, dir_up_next;
    logic                      is_load_reg, is_load_next;
    logic [rdc_pkg::DIST_W-1:0] out_data_reg, out_data_next;

    logic             out_free;
    logic [WIN_W-1:0] pick_idx;

    assign out_free        = !out_valid_reg || result.ready;
    assign clearing        = (state_reg == rdc_pkg::S_CLEAR);
    assign result.valid    = out_valid_reg;
    assign result.distinct = out_data_reg;

    // Sequencer: next state, memory controls and register updates.
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        wl_next        = wl_reg;
        wh_next        = wh_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        tl_next        = tl_reg;
        th_next        = th_reg;
        pos_next       = pos_reg;
        newval_next    = newval_reg;
        val_next       = val_reg;
        dir_up_next    = dir_up_reg;
        is_load_next   = is_load_reg;
        out_data_next  = out_data_reg;
        cmd_ready      = 1'b0;
        pick_idx       = '0;
        elem_re        = 1'b0;
        elem_raddr     = '0;
        elem_we        = 1'b0;
        elem_waddr     = '0;
        elem_wdata     = '0;
        occ_re         = 1'b0;
        occ_raddr      = '0;
        occ_we         = 1'b0;
        occ_waddr      = '0;
        occ_wdata      = '0;

        // A waiting result leaves once it is taken.
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rdc_pkg::S_CLEAR:
            begin
                // Zero the occurrence table one entry per cycle.
                occ_we       = 1'b1;
                occ_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == VAL_W'(rdc_pkg::VALUE_RANGE - 1))
                begin
                    state_next = rdc_pkg::S_IDLE;
                end
            end

            rdc_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_query)
                    begin
                        if (cmd.empty)
                        begin
                            // An empty range answers zero once the output register is free.
                            if (out_free)
                            begin
                                cmd_ready      = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                            end
                        end
                        else
                        begin
                            cmd_ready  = 1'b1;
                            tl_next    = cmd.t_low;
                            th_next    = cmd.t_high;
                            state_next = rdc_pkg::S_PICK;
                        end
                    end
                    else
                    begin
                        cmd_ready   = 1'b1;
                        pos_next    = cmd.pos;
                        newval_next = cmd.val;
                        if ((WIN_W'(cmd.pos) >= wl_reg) && (WIN_W'(cmd.pos) < wh_reg))
                        begin
                            // Inside the window: fetch the old value first.
                            elem_re      = 1'b1;
                            elem_raddr   = cmd.pos;
                            dir_up_next  = 1'b0;
                            is_load_next = 1'b1;
                            state_next   = rdc_pkg::S_ELEM;
                        end
                        else
                        begin
                            elem_we    = 1'b1;
                            elem_waddr = cmd.pos;
                            elem_wdata = cmd.val;
                        end
                    end
                end
            end

            rdc_pkg::S_PICK:
            begin
                // Grow the window before shrinking it.
                is_load_next = 1'b0;
                if (wh_reg < th_reg)
                begin
                    pick_idx    = wh_reg;
                    dir_up_next = 1'b1;
                    wh_next     = wh_reg + 1'b1;
                    state_next  = rdc_pkg::S_ELEM;
                end
                else if (wl_reg > tl_reg)
                begin
                    pick_idx    = wl_reg - 1'b1;
                    dir_up_next = 1'b1;
                    wl_next     = wl_reg - 1'b1;
                    state_next  = rdc_pkg::S_ELEM;
                end
                else if (wh_reg > th_reg)
                begin
                    pick_idx    = wh_reg - 1'b1;
                    dir_up_next = 1'b0;
                    wh_next     = wh_reg - 1'b1;
                    state_next  = rdc_pkg::S_ELEM;
                end
                else if (wl_reg < tl_reg)
                begin
                    pick_idx    = wl_reg;
                    dir_up_next = 1'b0;
                    wl_next     = wl_reg + 1'b1;
                    state_next  = rdc_pkg::S_ELEM;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rdc_pkg::DIST_W'(total_reg);
                    state_next     = rdc_pkg::S_IDLE;
                end
                elem_re    = (state_next == rdc_pkg::S_ELEM);
                elem_raddr = AIDX_W'(pick_idx);
            end

            rdc_pkg::S_ELEM:
            begin
                // Element is in hand: fetch its count.
                occ_re     = 1'b1;
                occ_raddr  = elem_rdata_reg;
                val_next   = elem_rdata_reg;
                state_next = rdc_pkg::S_OCCWR;
            end

            rdc_pkg::S_OCCWR:
            begin
                // Count update and distinct total on a zero crossing.
                occ_waddr = val_reg;
                if (dir_up_reg)
                begin
                    occ_we    = 1'b1;
                    occ_wdata = occ_rdata_reg + 1'b1;
                    if (occ_rdata_reg == '0)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
                else if (occ_rdata_reg != '0)
                begin
                    occ_we    = 1'b1;
                    occ_wdata = occ_rdata_reg - 1'b1;
                    if (occ_rdata_reg == CNT_W'(1))
                    begin
                        total_next = total_reg - 1'b1;
                    end
                end
                if (is_load_reg && !dir_up_reg)
                begin
                    state_next = rdc_pkg::S_LUPRD;
                end
                else if (is_load_reg)
                begin
                    state_next = rdc_pkg::S_IDLE;
                end
                else
                begin
                    state_next = rdc_pkg::S_PICK;
                end
            end

            rdc_pkg::S_LUPRD:
            begin
                // Load inside the window: count the new value and store it.
                occ_re      = 1'b1;
                occ_raddr   = newval_reg;
                val_next    = newval_reg;
                dir_up_next = 1'b1;
                elem_we     = 1'b1;
                elem_waddr  = pos_reg;
                elem_wdata  = newval_reg;
                state_next  = rdc_pkg::S_OCCWR;
            end

            default:
            begin
                state_next = rdc_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdc_pkg::S_CLEAR;
            clr_idx_reg   <= '0;
            wl_reg        <= '0;
            wh_reg        <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            wl_reg        <= wl_next;
            wh_reg        <= wh_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tl_reg       <= tl_next;
        th_reg       <= th_next;
        pos_reg      <= pos_next;
        newval_reg   <= newval_next;
        val_reg      <= val_next;
        dir_up_reg   <= dir_up_next;
        is_load_reg  <= is_load_next;
        out_data_reg <= out_data_next;
    end

    // Element array.
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re)
        begin
            elem_rdata_reg <= elem_mem[elem_raddr];
        end
    end

    // Occurrence table.
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        if (occ_re)
        begin
            occ_rdata_reg <= occ_mem[occ_raddr];
        end
    end

endmodule

>>> design/range_distinct_count_window_top.sv
// ---------------------------------------------------------------------------
// range_distinct_count_window_top: distinct-value count over index ranges
// Keeps an element array and a sliding window with per-value counts; loads
// write elements, queries move the window onto the range and return the
// number of different values in it.
//
//   Channel   Direction   Transfer carries
//   item      in          op, position, element_value, range_left, range_right
//   result    out         distinct (one per query, none per load)
//
// A load outside the current window and an empty-range query are absorbed
// directly in the idle state; a load inside the window takes two count
// read-modify-writes of the window engine.
// A query moves each window end one position per step; each step is an
// element read followed by a count read-modify-write.
// After reset all VALUE_RANGE (1024) entries of the count table are cleared,
// and item.ready is low during the clearing pass.
// A stalled result sits in the output register while the queue keeps taking
// items until it is full.
// ---------------------------------------------------------------------------
module range_distinct_count_window_top
(
    input  logic         clk,
    input  logic         rst_n,
    rdc_item_if.sink     item,
    rdc_result_if.source result
);

    logic          clearing;
    logic          push_valid;
    logic          push_ready;
    rdc_pkg::cmd_t push_data;
    logic          pop_valid;
    logic          pop_ready;
    rdc_pkg::cmd_t pop_data;

    // Intake and classification.
    rdc_front u_front
    (
        .clearing   (clearing),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Command queue.
    rdc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Window engine.
    rdc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_data),
        .clearing  (clearing),
        .result    (result)
    );

endmodule

>>> design/rdc_checker.sv
// ---------------------------------------------------------------------------
// rdc_checker: port-level checks for the distinct-count block
// Watches the top-level channels for result bounds, ordering against accepted
// queries, the clearing pass after reset and result hold under stall.
// ---------------------------------------------------------------------------
module rdc_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_op,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rdc_pkg::DIST_W-1:0] out_distinct
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       query_in;
    logic       result_out;

    assign query_in   = in_valid && in_ready && (in_op == rdc_pkg::OP_QUERY);
    assign result_out = out_valid && out_ready;

    // Queries accepted but not yet answered.
    always_comb
    begin
        pending_next = pending_reg;
        if (query_in && !result_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (result_out && !query_in)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Every result answers an earlier accepted query.
    a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
        result_out |-> (pending_reg != '0))
        else $error("result transfer without an outstanding query");

    // A window never holds more distinct values than positions.
    a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_distinct <= rdc_pkg::DIST_W'(rdc_pkg::ARRAY_DEPTH)))
        else $error("distinct count exceeds the array depth");

    // The count table is being cleared straight after reset.
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_ready)
        else $error("items taken before the count table was cleared");

    // A stalled result keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_distinct)))
        else $error("stalled result dropped or changed");

endmodule

bind range_distinct_count_window_top rdc_checker u_rdc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .in_op        (item.op),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_distinct (result.distinct)
);

>>> tb/sv/tb_range_distinct_count_window_top.sv
// ---------------------------------------------------------------------------
// tb_range_distinct_count_window_top: self-checking bench for the window block
// Feeds element loads and range queries through the item channel. It keeps its
// own copy of the element array, value counts and window. It checks each
// distinct count on the result channel, in order, against that copy.
// ---------------------------------------------------------------------------
module tb_range_distinct_count_window_top;

    import rdc_pkg::*;

    localparam int FIELD_MAX        = (1 << FIELD_W) - 1;
    localparam int STALL_LIMIT      = 50000;
    localparam int HOLD_CYCLES      = 800;
    localparam int DRAIN_CYCLES     = 64;
    localparam int RANDOM_PER_PHASE = 312;
    localparam int NUM_PHASES       = 4;

    // One request as offered on the item channel.
    typedef struct
    {
        op_t                op;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] element_value;
        logic [FIELD_W-1:0] range_left;
        logic [FIELD_W-1:0] range_right;
    } request_t;

    logic clk;
    logic rst_n;

    rdc_item_if   item_bus();
    rdc_result_if result_bus();

    range_distinct_count_window_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    // Requests waiting to be offered, and distinct counts still owed by the block.
    request_t          pending_requests[$];
    logic [DIST_W-1:0] owed_counts[$];

    // Shadow copy of the block's array, counts and half-open window.
    logic [VAL_W-1:0] shadow_elements [ARRAY_DEPTH];
    int               shadow_occ [VALUE_RANGE];
    int               shadow_low;
    int               shadow_high;
    int               shadow_total;

    // Generator bookkeeping: which positions hold data and where the window sits.
    bit written [ARRAY_DEPTH];
    int filled_upto;
    int gen_low;
    int gen_high;
    bit gen_window_valid;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    bit item_fire;
    int results_seen;
    int error_count;
    int quiet_cycles;

    // Clock generation.
    always #5 clk = ~clk;

    // A value enters the window.
    function automatic void occ_up(int v);
        if (v >= VALUE_RANGE)
            return;
        shadow_occ[v]++;
        if (shadow_occ[v] == 1)
            shadow_total++;
    endfunction

    // A value leaves the window.
    function automatic void occ_down(int v);
        if (v >= VALUE_RANGE || shadow_occ[v] == 0)
            return;
        shadow_occ[v]--;
        if (shadow_occ[v] == 0)
            shadow_total--;
    endfunction

    // Apply one accepted request to the shadow state and record any count owed.
    function automatic void predict_transfer(request_t req);
        int pos;
        int val;
        int lo;
        int hi;
        int t_high;
        if (req.op == OP_LOAD)
        begin
            pos = req.position;
            val = req.element_value;
            if (pos >= ARRAY_DEPTH)
                return;
            if (val >= VALUE_RANGE)
                val = VALUE_RANGE - 1;
            if (pos >= shadow_low && pos < shadow_high)
            begin
                occ_down(shadow_elements[pos]);
                occ_up(val);
            end
            shadow_elements[pos] = VAL_W'(val);
        end
        else
        begin
            lo = req.range_left;
            hi = req.range_right;
            if (hi >= ARRAY_DEPTH)
                hi = ARRAY_DEPTH - 1;
            if (lo > hi)
            begin
                owed_counts.insert(owed_counts.size(), '0);
                return;
            end
            t_high = hi + 1;
            // Grow first, then shrink, so no count goes below zero.
            while (shadow_high < t_high)
            begin
                occ_up(shadow_elements[shadow_high]);
                shadow_high++;
            end
            while (shadow_low > lo)
            begin
                shadow_low--;
                occ_up(shadow_elements[shadow_low]);
            end
            while (shadow_high > t_high)
            begin
                shadow_high--;
                occ_down(shadow_elements[shadow_high]);
            end
            while (shadow_low < lo)
            begin
                occ_down(shadow_elements[shadow_low]);
                shadow_low++;
            end
            owed_counts.insert(owed_counts.size(), DIST_W'(shadow_total));
        end
    endfunction

    // Queue a load and extend the run of written positions from zero.
    function automatic void queue_load(int pos, int val);
        request_t req;
        req.op            = OP_LOAD;
        req.position      = FIELD_W'(pos);
        req.element_value = FIELD_W'(val);
        req.range_left    = FIELD_W'($urandom);
        req.range_right   = FIELD_W'($urandom);
        pending_requests.insert(pending_requests.size(), req);
        written[pos] = 1'b1;
        while (filled_upto < ARRAY_DEPTH && written[filled_upto])
            filled_upto++;
    endfunction

    // Queue a query; a non-empty one becomes the new window.
    function automatic void queue_query(int lo, int hi);
        request_t req;
        req.op            = OP_QUERY;
        req.position      = FIELD_W'($urandom);
        req.element_value = FIELD_W'($urandom);
        req.range_left    = FIELD_W'(lo);
        req.range_right   = FIELD_W'(hi);
        pending_requests.insert(pending_requests.size(), req);
        if (lo <= hi)
        begin
            gen_low          = lo;
            gen_high         = hi;
            gen_window_valid = 1'b1;
        end
    endfunction

    // Random request. Non-empty ranges stay inside the written prefix, so the
    // window never passes over a position that was never loaded.
    function automatic void queue_random_request();
        int r;
        int pos;
        int val;
        int lo;
        int hi;
        int tmp;
        r = $urandom_range(99);
        if (r < ((filled_upto < ARRAY_DEPTH) ? 55 : 25))
        begin
            r = $urandom_range(99);
            if (filled_upto < ARRAY_DEPTH && r < 70)
                pos = filled_upto;
            else if (gen_window_valid && r < 88)
                pos = $urandom_range(gen_high, gen_low);
            else
                pos = $urandom_range(ARRAY_DEPTH - 1);
            r = $urandom_range(99);
            if (r < 50)
                val = $urandom_range(15);
            else if (r < 90)
                val = $urandom_range(VALUE_RANGE - 1);
            else
                val = (r < 95) ? 0 : VALUE_RANGE - 1;
            queue_load(pos, val);
        end
        else
        begin
            r = $urandom_range(99);
            if (filled_upto == 0 || r < 10)
            begin
                lo = $urandom_range(FIELD_MAX, 1);
                hi = $urandom_range(lo - 1, 0);
            end
            else if (r < 20)
            begin
                lo = $urandom_range(filled_upto - 1);
                hi = $urandom_range(filled_upto - 1, lo);
            end
            else
            begin
                // Mostly short moves of both window ends, as in sorted query order.
                lo = gen_low + int'($urandom_range(32)) - 16;
                hi = gen_high + int'($urandom_range(32)) - 16;
                if (lo < 0)
                    lo = 0;
                if (hi < 0)
                    hi = 0;
                if (lo > filled_upto - 1)
                    lo = filled_upto - 1;
                if (hi > filled_upto - 1)
                    hi = filled_upto - 1;
                if (lo > hi)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
            queue_query(lo, hi);
        end
    endfunction

    // Item driver: a new request goes out once the previous one has transferred.
    always @(negedge clk)
    begin : drive_items
        request_t req;
        if (rst_n && (!item_bus.valid || item_fire))
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req = pending_requests.pop_front();
                item_bus.valid         <= 1'b1;
                item_bus.op            <= req.op;
                item_bus.position      <= req.position;
                item_bus.element_value <= req.element_value;
                item_bus.range_left    <= req.range_left;
                item_bus.range_right   <= req.range_right;
            end
            else
            begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // Result acceptance with random stalls and the long hold-off.
    always @(negedge clk)
    begin
        result_bus.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long hold-off on the result side while items keep coming.
    initial
    begin
        wait (results_seen >= 3);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Monitor: check each result transfer, then predict from each item transfer.
    always @(posedge clk)
    begin : check_transfers
        request_t          req;
        logic [DIST_W-1:0] want;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                results_seen++;
                if (owed_counts.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected distinct count: expected none, actual %0d",
                             $time, result_bus.distinct);
                end
                else
                begin
                    want = owed_counts.pop_front();
                    if (result_bus.distinct !== want)
                    begin
                        error_count++;
                        $display("%0t: distinct mismatch: expected %0d, actual %0d",
                                 $time, want, result_bus.distinct);
                    end
                end
            end
            item_fire = item_bus.valid && item_bus.ready;
            if (item_fire)
            begin
                req.op            = op_t'(item_bus.op);
                req.position      = item_bus.position;
                req.element_value = item_bus.element_value;
                req.range_left    = item_bus.range_left;
                req.range_right   = item_bus.range_right;
                predict_transfer(req);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n && !(item_bus.valid && item_bus.ready)
            && !(result_bus.valid && result_bus.ready))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reset, stimulus phases and the final verdict.
    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        item_bus.valid         = 1'b0;
        item_bus.op            = OP_LOAD;
        item_bus.position      = '0;
        item_bus.element_value = '0;
        item_bus.range_left    = '0;
        item_bus.range_right   = '0;
        result_bus.ready       = 1'b0;
        hold_off               = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase

            if (phase == 0)
            begin
                // Empty ranges before anything is loaded, extremes of both fields.
                queue_query(FIELD_MAX, 0);
                queue_query(5, 4);
                // Extreme values and the last array position.
                queue_load(0, 0);
                queue_load(1, VALUE_RANGE - 1);
                queue_load(2, 0);
                queue_load(3, 512);
                queue_load(ARRAY_DEPTH - 1, VALUE_RANGE - 1);
                // Window grows high, shrinks at both ends, then grows at both ends.
                queue_query(0, 0);
                queue_query(0, 3);
                queue_query(1, 1);
                queue_query(0, 3);
                // Loads inside the window: same total, value swap, value lost.
                queue_load(2, VALUE_RANGE - 1);
                queue_load(0, 7);
                queue_load(3, VALUE_RANGE - 1);
                // Load outside the window, then a query that does not move it.
                queue_load(4, 5);
                queue_query(0, 3);
                queue_query(2, 4);
                // Single position, an empty range in between, and the same range again.
                queue_query(4, 4);
                queue_query(3, 2);
                queue_query(4, 4);
                queue_load(4, VALUE_RANGE - 1);
                queue_query(0, 4);
            end

            repeat (RANDOM_PER_PHASE) queue_random_request();

            while (pending_requests.size() != 0 || item_bus.valid || owed_counts.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && owed_counts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
design/rdc_pkg.sv
design/rdc_item_if.sv
design/rdc_result_if.sv
design/rdc_front.sv
design/rdc_queue.sv
design/rdc_back.sv
design/range_distinct_count_window_top.sv
design/rdc_checker.sv
tb/sv/tb_range_distinct_count_window_top.sv
